// ===== src/calendar_date_arithmetic_macros.svh =====
// assertion macros for the calendar date unit
// define ASSERT_OFF to compile the checks out
`ifndef CALENDAR_DATE_ARITHMETIC_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle
`define CDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define CDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// types, constants and tables shared by the calendar date unit
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    // year window
    localparam int BASE_YEAR = 1970;
    localparam int LAST_YEAR = 2050;

    // field widths
    localparam int ACT_W  = 3;
    localparam int YEAR_W = 12;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int OFF_W  = 15;
    localparam int IVL_W  = 16;
    localparam int WDAY_W = 3;
    localparam int STAT_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INTERVAL = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_VALIDATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WEEKDAY  = 3'd4;

    // validation status codes
    localparam logic [STAT_W-1:0] CHK_OK        = 2'd0;
    localparam logic [STAT_W-1:0] CHK_BAD_DAY   = 2'd1;
    localparam logic [STAT_W-1:0] CHK_BAD_MONTH = 2'd2;
    localparam logic [STAT_W-1:0] CHK_BAD_YEAR  = 2'd3;

    // days in years 0 .. y-1, elaboration only
    function automatic int days_before_year(input int y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    localparam int BASE_DAYS = days_before_year(BASE_YEAR);
    localparam int TOP_DAYS  = days_before_year(LAST_YEAR + 1) - BASE_DAYS;

    // absolute day count of any 12-bit date, and the weekday word
    localparam int ABS_W = 21;
    localparam int WD_W  = ABS_W + 1;

    // weekday word split into octal digits
    localparam int WD_DIG   = (WD_W + 2) / 3;
    localparam int WD_PAD_W = 3 * WD_DIG;

    // signed day number after adding or subtracting the offset
    localparam int NUM_W = ABS_W + 2;
    localparam logic signed [NUM_W-1:0] BASE_NUM = NUM_W'(BASE_DAYS);
    localparam logic signed [NUM_W-1:0] TOP_NUM  = NUM_W'(TOP_DAYS);

    // remaining day count during the year and month walk
    localparam int REM_W = $clog2(TOP_DAYS + 1);

    // reciprocal division by one hundred
    localparam int YX_W      = YEAR_W + 1;
    localparam int PROD_W    = 26;
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SH  = 19;
    localparam int Q100_W    = 6;
    localparam int Q400_W    = 4;

    // running year remainders in the year walk
    localparam int YM100_W = 7;
    localparam int YM400_W = 9;

    // days before a month, and days in a year
    localparam int MB_W = 9;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [YEAR_W-1:0] year_a;
        logic [MON_W-1:0]  month_a;
        logic [DAY_W-1:0]  day_a;
        logic [YEAR_W-1:0] year_b;
        logic [MON_W-1:0]  month_b;
        logic [DAY_W-1:0]  day_b;
        logic [OFF_W-1:0]  offset_days;
    } item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]       out_year;
        logic [MON_W-1:0]        out_month;
        logic [DAY_W-1:0]        out_day;
        logic signed [IVL_W-1:0] interval;
        logic [WDAY_W-1:0]       weekday;
        logic [STAT_W-1:0]       check_status;
        logic                    range_error;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_SUM_A,
        ST_MUL_B,
        ST_SUM_B,
        ST_WDAY,
        ST_ADJ,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc_mul;
        logic calc_sum;
        logic sel_b;
        logic wd_fold;
        logic adj;
        logic yr_step;
        logic mo_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic act_defined;
        logic act_interval;
        logic act_addsub;
        logic yr_more;
        logic mo_more;
    } stat_t;

    // length of a month, index 0 is january, no leap day
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] idx);
        logic [DAY_W-1:0] len;
        case (idx)
            4'd1:                   len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the first k months, no leap day
    function automatic logic [MB_W-1:0] cum_days(input logic [MON_W-1:0] k);
        logic [MB_W-1:0] s;
        case (k)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd365;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/cda_datapath.sv =====
// ----------------------------------------------------------------------------
// cda_datapath
// day count unit, weekday remainder, year and month walk and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_arithmetic_macros.svh"

module cda_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cda_pkg::item_t    item,
    input  wire cda_pkg::cmd_t     cmd,
    output cda_pkg::stat_t         stat,
    output cda_pkg::result_t       result,
    output logic                   done
);

    cda_pkg::item_t   item_reg;
    cda_pkg::result_t result_reg;
    cda_pkg::result_t result_next;
    logic             done_reg;

    logic [cda_pkg::ABS_W-1:0]  y365_reg;
    logic [cda_pkg::Q100_W-1:0] q100_reg;
    logic [cda_pkg::Q400_W-1:0] q400_reg;
    logic [cda_pkg::ABS_W-1:0]  abs_a_reg;
    logic [cda_pkg::ABS_W-1:0]  abs_b_reg;
    logic                       leap_a_reg;

    logic [cda_pkg::WD_W-1:0]   wd_arg_reg;
    logic [2:0]                 wd_rem_reg;

    logic [cda_pkg::REM_W-1:0]   rem_reg;
    logic [cda_pkg::YEAR_W-1:0]  y_reg;
    logic [cda_pkg::MON_W-1:0]   m_reg;
    logic [cda_pkg::YM100_W-1:0] ym100_reg;
    logic [cda_pkg::YM400_W-1:0] ym400_reg;
    logic                        rerr_reg;

    // date select for the day count unit
    logic [cda_pkg::YEAR_W-1:0] sel_year;
    logic [cda_pkg::MON_W-1:0]  sel_month;
    logic [cda_pkg::DAY_W-1:0]  sel_day;
    logic [cda_pkg::YX_W-1:0]   y_ext;

    assign sel_year  = cmd.sel_b ? item_reg.year_b  : item_reg.year_a;
    assign sel_month = cmd.sel_b ? item_reg.month_b : item_reg.month_a;
    assign sel_day   = cmd.sel_b ? item_reg.day_b   : item_reg.day_a;
    assign y_ext     = {1'b0, sel_year};

    // first step: year products and century counts by reciprocal
    logic [cda_pkg::YX_W-1:0]   ceil100_arg;
    logic [cda_pkg::YX_W-1:0]   ceil400_arg;
    logic [cda_pkg::PROD_W-1:0] prod100;
    logic [cda_pkg::PROD_W-1:0] prod400;
    logic [cda_pkg::ABS_W-1:0]  y365;

    assign ceil100_arg = y_ext + cda_pkg::YX_W'(99);
    assign ceil400_arg = (y_ext + cda_pkg::YX_W'(399)) >> 2;
    assign prod100 = cda_pkg::PROD_W'(ceil100_arg) * cda_pkg::PROD_W'(cda_pkg::RECIP_100);
    assign prod400 = cda_pkg::PROD_W'(ceil400_arg) * cda_pkg::PROD_W'(cda_pkg::RECIP_100);
    assign y365    = cda_pkg::ABS_W'(sel_year) * cda_pkg::ABS_W'(365);

    // second step: leap rule and absolute day count
    logic [cda_pkg::YX_W-1:0]  mul100;
    logic [cda_pkg::YX_W-1:0]  mul400;
    logic                      is_leap;
    logic [cda_pkg::MON_W-1:0] mon_k;
    logic [cda_pkg::MB_W-1:0]  mon_before;
    logic [cda_pkg::YX_W-1:0]  div4;
    logic [cda_pkg::ABS_W-1:0] abs_sum;

    assign mul100  = cda_pkg::YX_W'(q100_reg) * cda_pkg::YX_W'(100);
    assign mul400  = cda_pkg::YX_W'(q400_reg) * cda_pkg::YX_W'(400);
    assign is_leap = ((sel_year[1:0] == 2'b00) && (mul100 != y_ext)) || (mul400 == y_ext);
    assign div4    = (y_ext + cda_pkg::YX_W'(3)) >> 2;

    always_comb
    begin
        if (sel_month == '0)
        begin
            mon_k = '0;
        end
        else if (sel_month > 4'd13)
        begin
            mon_k = 4'd12;
        end
        else
        begin
            mon_k = sel_month - 4'd1;
        end
    end

    assign mon_before = cda_pkg::cum_days(mon_k)
                      + cda_pkg::MB_W'(is_leap && (mon_k >= 4'd2));

    assign abs_sum = y365_reg + cda_pkg::ABS_W'(div4) - cda_pkg::ABS_W'(q100_reg)
                   + cda_pkg::ABS_W'(q400_reg) + cda_pkg::ABS_W'(mon_before)
                   + cda_pkg::ABS_W'(sel_day);

    // weekday remainder from the sum of octal digits, eight being one modulo seven
    logic [cda_pkg::WD_PAD_W-1:0] wd_pad;
    logic [5:0]                   wd_sum;
    logic [3:0]                   wd_fold1;
    logic [2:0]                   wd_fold2;
    logic [2:0]                   wd_rem_next;

    assign wd_pad = cda_pkg::WD_PAD_W'(wd_arg_reg);

    always_comb
    begin
        wd_sum = '0;
        for (int i = 0; i < cda_pkg::WD_DIG; i++)
        begin
            wd_sum = wd_sum + 6'(wd_pad[3*i +: 3]);
        end
    end

    assign wd_fold1    = 4'(wd_sum[5:3]) + 4'(wd_sum[2:0]);
    assign wd_fold2    = 3'(wd_fold1[3]) + wd_fold1[2:0];
    assign wd_rem_next = (wd_fold2 == 3'd7) ? 3'd0 : wd_fold2;

    // day number with the offset applied, clamped to the window
    logic signed [cda_pkg::NUM_W-1:0] day_num;
    logic signed [cda_pkg::NUM_W-1:0] off_ext;
    logic signed [cda_pkg::NUM_W-1:0] shifted;

    assign day_num = $signed(cda_pkg::NUM_W'(abs_a_reg)) - cda_pkg::BASE_NUM;
    assign off_ext = $signed(cda_pkg::NUM_W'(item_reg.offset_days));
    assign shifted = (item_reg.action == cda_pkg::ACT_ADD) ? day_num + off_ext
                                                           : day_num - off_ext;

    // year and month lengths for the walk
    logic                       leap_y;
    logic [cda_pkg::MB_W-1:0]   year_len;
    logic [cda_pkg::DAY_W-1:0]  mon_len;

    assign leap_y   = ((y_reg[1:0] == 2'b00) && (ym100_reg != '0)) || (ym400_reg == '0);
    assign year_len = cda_pkg::MB_W'(365) + cda_pkg::MB_W'(leap_y);
    assign mon_len  = cda_pkg::month_days(m_reg - 4'd1)
                    + cda_pkg::DAY_W'((m_reg == 4'd2) && leap_y);

    // status to the controller
    always_comb
    begin
        stat.act_defined  = (item_reg.action <= cda_pkg::ACT_WEEKDAY);
        stat.act_interval = (item_reg.action == cda_pkg::ACT_INTERVAL);
        stat.act_addsub   = (item_reg.action == cda_pkg::ACT_ADD)
                         || (item_reg.action == cda_pkg::ACT_SUB);
        stat.yr_more      = (y_reg < cda_pkg::YEAR_W'(cda_pkg::LAST_YEAR))
                         && (rem_reg > cda_pkg::REM_W'(year_len));
        stat.mo_more      = (m_reg < 4'd12) && (rem_reg > cda_pkg::REM_W'(mon_len));
    end

    // interval with saturation to 16 bits
    logic signed [cda_pkg::ABS_W:0] diff;
    logic                           diff_fits;
    logic [cda_pkg::IVL_W-1:0]      ivl;

    assign diff      = $signed({1'b0, abs_b_reg}) - $signed({1'b0, abs_a_reg});
    assign diff_fits = (&diff[cda_pkg::ABS_W:cda_pkg::IVL_W-1])
                    || !(|diff[cda_pkg::ABS_W:cda_pkg::IVL_W-1]);
    assign ivl       = diff_fits ? diff[cda_pkg::IVL_W-1:0]
                     : {diff[cda_pkg::ABS_W], {(cda_pkg::IVL_W-1){~diff[cda_pkg::ABS_W]}}};

    // validation of date a
    logic [cda_pkg::DAY_W-1:0]  len_a;
    logic [cda_pkg::STAT_W-1:0] chk;

    assign len_a = cda_pkg::month_days(item_reg.month_a - 4'd1)
                 + cda_pkg::DAY_W'((item_reg.month_a == 4'd2) && leap_a_reg);

    always_comb
    begin
        if ((item_reg.year_a < cda_pkg::YEAR_W'(cda_pkg::BASE_YEAR))
            || (item_reg.year_a > cda_pkg::YEAR_W'(cda_pkg::LAST_YEAR)))
        begin
            chk = cda_pkg::CHK_BAD_YEAR;
        end
        else if ((item_reg.month_a == '0) || (item_reg.month_a > 4'd12))
        begin
            chk = cda_pkg::CHK_BAD_MONTH;
        end
        else if ((item_reg.day_a == '0) || (item_reg.day_a > len_a))
        begin
            chk = cda_pkg::CHK_BAD_DAY;
        end
        else
        begin
            chk = cda_pkg::CHK_OK;
        end
    end

    // result assembly
    always_comb
    begin
        result_next = '0;
        if (stat.act_defined)
        begin
            result_next.weekday = cda_pkg::WDAY_W'(wd_rem_reg) + cda_pkg::WDAY_W'(1);
        end
        if (stat.act_interval)
        begin
            result_next.interval = $signed(ivl);
        end
        if (stat.act_addsub)
        begin
            result_next.out_year    = y_reg;
            result_next.out_month   = m_reg;
            result_next.out_day     = rem_reg[cda_pkg::DAY_W-1:0];
            result_next.range_error = rerr_reg;
        end
        if (item_reg.action == cda_pkg::ACT_VALIDATE)
        begin
            result_next.check_status = chk;
        end
    end

    // item capture and day count registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.calc_mul)
        begin
            y365_reg <= y365;
            q100_reg <= prod100[cda_pkg::RECIP_SH +: cda_pkg::Q100_W];
            q400_reg <= prod400[cda_pkg::RECIP_SH +: cda_pkg::Q400_W];
        end
        if (cmd.calc_sum)
        begin
            if (cmd.sel_b)
            begin
                abs_b_reg <= abs_sum;
            end
            else
            begin
                abs_a_reg  <= abs_sum;
                leap_a_reg <= is_leap;
                wd_arg_reg <= cda_pkg::WD_W'(abs_sum) + cda_pkg::WD_W'(4);
            end
        end
        else if (cmd.wd_fold)
        begin
            wd_rem_reg <= wd_rem_next;
        end
    end

    // year and month walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.adj)
        begin
            y_reg     <= cda_pkg::YEAR_W'(cda_pkg::BASE_YEAR);
            m_reg     <= 4'd1;
            ym100_reg <= cda_pkg::YM100_W'(cda_pkg::BASE_YEAR % 100);
            ym400_reg <= cda_pkg::YM400_W'(cda_pkg::BASE_YEAR % 400);
            if (shifted[cda_pkg::NUM_W-1] || (shifted == '0))
            begin
                rem_reg  <= cda_pkg::REM_W'(1);
                rerr_reg <= 1'b1;
            end
            else if (shifted > cda_pkg::TOP_NUM)
            begin
                rem_reg  <= cda_pkg::REM_W'(cda_pkg::TOP_DAYS);
                rerr_reg <= 1'b1;
            end
            else
            begin
                rem_reg  <= shifted[cda_pkg::REM_W-1:0];
                rerr_reg <= 1'b0;
            end
        end
        else if (cmd.yr_step)
        begin
            rem_reg   <= rem_reg - cda_pkg::REM_W'(year_len);
            y_reg     <= y_reg + cda_pkg::YEAR_W'(1);
            ym100_reg <= (ym100_reg == cda_pkg::YM100_W'(99)) ? '0
                                                              : ym100_reg + cda_pkg::YM100_W'(1);
            ym400_reg <= (ym400_reg == cda_pkg::YM400_W'(399)) ? '0
                                                               : ym400_reg + cda_pkg::YM400_W'(1);
        end
        else if (cmd.mo_step)
        begin
            rem_reg <= rem_reg - cda_pkg::REM_W'(mon_len);
            m_reg   <= m_reg + 4'd1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    // checks
    `CDA_ASSERT_SAME(a_year_walk_bound, clk, rst_n, cmd.yr_step, y_reg < cda_pkg::YEAR_W'(cda_pkg::LAST_YEAR), "year walk stepped past the last year")
    `CDA_ASSERT_SAME(a_range_saturates, clk, rst_n, done_reg && result_reg.range_error, (result_reg.out_year == cda_pkg::YEAR_W'(cda_pkg::BASE_YEAR)) || (result_reg.out_year == cda_pkg::YEAR_W'(cda_pkg::LAST_YEAR)), "range error without a saturated year")
    `CDA_ASSERT_SAME(a_zero_weekday_blank, clk, rst_n, done_reg && (result_reg.weekday == '0), (result_reg.interval == '0) && (result_reg.check_status == '0) && !result_reg.range_error, "blank weekday with other fields set")

endmodule

`default_nettype wire

// ===== src/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl
// sequencer for the date unit: day counts, weekday, year and month walk
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_arithmetic_macros.svh"

module cda_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire cda_pkg::stat_t   stat,
    output cda_pkg::cmd_t         cmd,
    output logic                  busy
);

    cda_pkg::state_t state_reg;
    cda_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            cda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = cda_pkg::ST_MUL_A;
                end
            end
            cda_pkg::ST_MUL_A:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = cda_pkg::ST_SUM_A;
            end
            cda_pkg::ST_SUM_A:
            begin
                cmd.calc_sum = 1'b1;
                if (!stat.act_defined)
                begin
                    state_next = cda_pkg::ST_FINISH;
                end
                else if (stat.act_interval)
                begin
                    state_next = cda_pkg::ST_MUL_B;
                end
                else
                begin
                    state_next = cda_pkg::ST_WDAY;
                end
            end
            cda_pkg::ST_MUL_B:
            begin
                cmd.calc_mul = 1'b1;
                cmd.sel_b    = 1'b1;
                state_next   = cda_pkg::ST_SUM_B;
            end
            cda_pkg::ST_SUM_B:
            begin
                cmd.calc_sum = 1'b1;
                cmd.sel_b    = 1'b1;
                state_next   = cda_pkg::ST_WDAY;
            end
            cda_pkg::ST_WDAY:
            begin
                cmd.wd_fold = 1'b1;
                state_next  = stat.act_addsub ? cda_pkg::ST_ADJ : cda_pkg::ST_FINISH;
            end
            cda_pkg::ST_ADJ:
            begin
                cmd.adj    = 1'b1;
                state_next = cda_pkg::ST_YEAR;
            end
            cda_pkg::ST_YEAR:
            begin
                if (stat.yr_more)
                begin
                    cmd.yr_step = 1'b1;
                end
                else
                begin
                    state_next = cda_pkg::ST_MONTH;
                end
            end
            cda_pkg::ST_MONTH:
            begin
                if (stat.mo_more)
                begin
                    cmd.mo_step = 1'b1;
                end
                else
                begin
                    state_next = cda_pkg::ST_FINISH;
                end
            end
            cda_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = cda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != cda_pkg::ST_IDLE);

    // checks
    `CDA_ASSERT_NEXT(a_wday_single, clk, rst_n, state_reg == cda_pkg::ST_WDAY, state_reg != cda_pkg::ST_WDAY, "weekday step repeated")
    `CDA_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, cmd.finish, (state_reg == cda_pkg::ST_IDLE) && !$past(busy) == 1'b0, "finish not followed by idle")
    `CDA_ASSERT_SAME(a_idle_quiet, clk, rst_n, state_reg == cda_pkg::ST_IDLE, !(cmd.yr_step || cmd.mo_step || cmd.finish || cmd.calc_sum || cmd.wd_fold), "datapath command while idle")

endmodule

`default_nettype wire

// ===== src/calendar_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// validate and weekday count the days of date a and fold the weekday;
// interval also counts date b; add and subtract then walk the years, one
// year a cycle, and then the months. an unused action skips all but the
// first day count. one item at a time; busy drops in the done cycle, so the
// next item can be taken there. reset clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_arithmetic (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire cda_pkg::item_t   item,
    output logic                  busy,
    output logic                  done,
    output cda_pkg::result_t      result
);

    cda_pkg::cmd_t  cmd;
    cda_pkg::stat_t stat;

    // sequencer
    cda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // arithmetic and result register
    cda_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire
